[src/pls_pkg.sv]
`default_nettype none
package pls_pkg;

  // Cell indexes are carried at the width that the largest supported depth needs.
  localparam int unsigned TGT_W = 6;

  localparam logic [2:0] FN_INS_FRONT = 3'd0;
  localparam logic [2:0] FN_INS_BACK  = 3'd1;
  localparam logic [2:0] FN_INS_POS   = 3'd2;
  localparam logic [2:0] FN_DEL_FRONT = 3'd3;
  localparam logic [2:0] FN_DEL_BACK  = 3'd4;
  localparam logic [2:0] FN_DEL_POS   = 3'd5;
  localparam logic [2:0] FN_DUMP      = 3'd6;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL,
    OP_ROT
  } cell_op_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_t          op;
    logic [TGT_W-1:0]  tgt;
    logic signed [31:0] value;
  } cell_ctl_t;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
    logic [7:0]         position;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         count;
    logic signed [31:0] item;
    logic               item_valid;
    logic               last;
  } result_t;

endpackage
`default_nettype wire

[src/positional_list_store.sv]
// Insert, delete and no-op commands: result strobed in the cycle after acceptance; one per
// cycle while no dump runs. Dump of a non-empty list: count results on consecutive cycles,
// the first once the state has moved to S_DUMP; busy is high while the chain rotates.
// Next transaction: taken from the cycle of the last result on. An empty dump gives one result.
// Synchronous active-high reset empties the list and clears the strobe and busy.
// The receiver cannot stall: every result is valid only in the cycle that done is high.
`default_nettype none
module positional_list_store #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire pls_pkg::cmd_t    cmd,
  output logic                  done,
  output pls_pkg::result_t      result
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_next;
  logic [CNT_W-1:0]      rem;
  pls_pkg::cell_ctl_t    ctl;
  logic [1:0]            status_next;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic [8:0]            pos_ext;
  logic [8:0]            cnt_ext;
  logic signed [31:0]    cell_q [DEPTH];

  assign accept  = start && (state == S_IDLE);
  assign busy    = (state == S_DUMP);
  assign full    = (cnt == CNT_W'(DEPTH));
  assign empty   = (cnt == '0);
  assign pos_ext = {1'b0, cmd.position};
  assign cnt_ext = 9'(cnt);

  // Decode one command into the chain control, the new count and the status. While a dump
  // runs, the chain rotates by one element each cycle with the wrap point at the last
  // occupied cell, so once count rotations are done the list stands in its original order again.
  always_comb begin
    ctl.op      = pls_pkg::OP_HOLD;
    ctl.tgt     = '0;
    ctl.value   = cmd.value;
    cnt_next    = cnt;
    status_next = pls_pkg::ST_OK;
    if (state == S_DUMP) begin
      ctl.op  = pls_pkg::OP_ROT;
      ctl.tgt = pls_pkg::TGT_W'(cnt - 1'b1);
    end else if (accept) begin
      case (cmd.func)
        pls_pkg::FN_INS_FRONT: begin
          if (full) begin
            status_next = pls_pkg::ST_FULL;
          end else begin
            ctl.op   = pls_pkg::OP_INS;
            cnt_next = cnt + 1'b1;
          end
        end
        pls_pkg::FN_INS_BACK: begin
          if (full) begin
            status_next = pls_pkg::ST_FULL;
          end else begin
            ctl.op   = pls_pkg::OP_INS;
            ctl.tgt  = pls_pkg::TGT_W'(cnt);
            cnt_next = cnt + 1'b1;
          end
        end
        pls_pkg::FN_INS_POS: begin
          // The position check comes ahead of the full check.
          if (pos_ext == 9'd0 || pos_ext > cnt_ext + 9'd1) begin
            status_next = pls_pkg::ST_BADPOS;
          end else if (full) begin
            status_next = pls_pkg::ST_FULL;
          end else begin
            ctl.op   = pls_pkg::OP_INS;
            ctl.tgt  = pls_pkg::TGT_W'(cmd.position - 8'd1);
            cnt_next = cnt + 1'b1;
          end
        end
        pls_pkg::FN_DEL_FRONT: begin
          if (empty) begin
            status_next = pls_pkg::ST_EMPTY;
          end else begin
            ctl.op   = pls_pkg::OP_DEL;
            cnt_next = cnt - 1'b1;
          end
        end
        pls_pkg::FN_DEL_BACK: begin
          if (empty) begin
            status_next = pls_pkg::ST_EMPTY;
          end else begin
            ctl.op   = pls_pkg::OP_DEL;
            ctl.tgt  = pls_pkg::TGT_W'(cnt - 1'b1);
            cnt_next = cnt - 1'b1;
          end
        end
        pls_pkg::FN_DEL_POS: begin
          // An empty list makes every position bad.
          if (pos_ext == 9'd0 || pos_ext > cnt_ext) begin
            status_next = pls_pkg::ST_BADPOS;
          end else begin
            ctl.op   = pls_pkg::OP_DEL;
            ctl.tgt  = pls_pkg::TGT_W'(cmd.position - 8'd1);
            cnt_next = cnt - 1'b1;
          end
        end
        pls_pkg::FN_DUMP: begin
          if (empty) status_next = pls_pkg::ST_EMPTY;
        end
        default: status_next = pls_pkg::ST_OK;
      endcase
    end
  end

  // The chain of element cells. Cell 0 holds the head of the list.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [31:0] left_in;
    logic signed [31:0] right_in;
    if (g == 0) begin : g_head
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_q[g+1];
    end
    pls_cell #(
      .IDX(g)
    ) u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .left (left_in),
      .right(right_in),
      .first(cell_q[0]),
      .q    (cell_q[g])
    );
  end

  // State, count and the registered result. A dump emits the head cell each cycle
  // while the chain rotates it away to the back.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      rem   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      cnt  <= cnt_next;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd.func == pls_pkg::FN_DUMP && !empty) begin
              state <= S_DUMP;
              rem   <= cnt;
            end else begin
              done              <= 1'b1;
              result.status     <= status_next;
              result.count      <= 5'(cnt_next);
              result.item       <= '0;
              result.item_valid <= 1'b0;
              result.last       <= 1'b1;
            end
          end
        end
        S_DUMP: begin
          done              <= 1'b1;
          result.status     <= pls_pkg::ST_OK;
          result.count      <= 5'(cnt);
          result.item       <= cell_q[0];
          result.item_valid <= 1'b1;
          result.last       <= (rem == CNT_W'(1));
          rem               <= rem - 1'b1;
          if (rem == CNT_W'(1)) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[src/pls_cell.sv]
`default_nettype none
module pls_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic               clk,
  input  wire pls_pkg::cell_ctl_t ctl,
  input  wire logic signed [31:0] left,
  input  wire logic signed [31:0] right,
  input  wire logic signed [31:0] first,
  output logic signed [31:0]      q
);

  localparam logic [pls_pkg::TGT_W-1:0] IDX_C = pls_pkg::TGT_W'(IDX);

  logic signed [31:0] q_next;

  // Insert opens a gap at the target by shifting the tail right; delete closes it by
  // shifting left; rotate moves every element one place toward the head, wrapping the
  // head element to the last occupied cell (the target).
  always_comb begin
    q_next = q;
    case (ctl.op)
      pls_pkg::OP_INS: begin
        if (IDX_C == ctl.tgt) q_next = ctl.value;
        else if (IDX_C > ctl.tgt) q_next = left;
      end
      pls_pkg::OP_DEL: begin
        if (IDX_C >= ctl.tgt) q_next = right;
      end
      pls_pkg::OP_ROT: begin
        if (IDX_C == ctl.tgt) q_next = first;
        else q_next = right;
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule
`default_nettype wire

[src/pls_checker.sv]
`default_nettype none
module pls_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             start,
  input wire logic             busy,
  input wire pls_pkg::cmd_t    cmd,
  input wire logic             done,
  input wire pls_pkg::result_t result
);

  // A dump that has not reached its final element continues in the next cycle.
  a_dump_continues: assert property (@(posedge clk) disable iff (rst)
    done && !result.last |=> done)
    else $error("dump stream broke before its final element");

  // Only dumped elements carry an item value.
  a_item_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.item_valid |-> result.item == 32'sd0)
    else $error("item nonzero without item_valid");

  // Non-final results only come from a dump of a non-empty list.
  a_mid_dump: assert property (@(posedge clk) disable iff (rst)
    done && !result.last |-> result.item_valid && result.status == pls_pkg::ST_OK)
    else $error("non-final result is not a dumped element");

  // Every accepted non-dump transaction answers with one final result next cycle.
  a_single: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.func != pls_pkg::FN_DUMP |=> done && result.last && !busy)
    else $error("single-result transaction did not complete");

  a_reset: assert property (@(posedge clk)
    rst |=> !busy && !done)
    else $error("reset did not clear control state");

endmodule

bind positional_list_store pls_checker u_pls_checker (.*);
`default_nettype wire

[test/tb_top.sv]
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pls_pkg::*;

  // Capacity of the list under test; the block is built with the same value.
  localparam int unsigned DEPTH = 16;

  // The function code left unused by the package. The block must answer it
  // with a plain OK result and leave the list alone.
  localparam logic [2:0] FN_UNUSED = 3'd7;

  // Number of trailing transactions that are issued back to back with no
  // idle cycles in between.
  localparam int QUIET_TAIL = 60;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  cmd_t    cmd;
  logic    done;
  result_t result;

  // Commands waiting to be handed to the block, filled once at time zero.
  cmd_t pending_cmds[$];
  int   cmd_total;
  int   cmds_issued = 0;
  int   gap_left;

  // The list contents as the block should hold them, front first, and the
  // results the block still owes us, oldest first.
  logic signed [31:0] list_shadow[$];
  result_t            awaited_results[$];
  int                 mismatch_count = 0;

  positional_list_store #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .result(result)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Applies one accepted command to the shadow list and queues the results
  // the block must produce for it. Every insert or delete answers with one
  // result that carries the count after the operation. A dump answers with
  // one result per stored element in list order, or a single EMPTY result
  // when there is nothing to show.
  function automatic void apply_command(cmd_t c);
    result_t     r;
    int unsigned p;
    int unsigned n;
    r = '0;
    r.last = 1'b1;
    n = list_shadow.size();
    p = 32'(c.position);
    case (c.func)
      FN_INS_FRONT, FN_INS_BACK, FN_INS_POS: begin
        // Front and back inserts are just inserts at a fixed position, so
        // they can never see a bad position, only a full list.
        if (c.func == FN_INS_FRONT) begin
          p = 1;
        end else if (c.func == FN_INS_BACK) begin
          p = n + 1;
        end
        // The position check wins over the full check.
        if (p < 1 || p > n + 1) begin
          r.status = ST_BADPOS;
        end else if (n >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_shadow.insert(p - 1, c.value);
          r.status = ST_OK;
        end
      end
      FN_DEL_FRONT, FN_DEL_BACK: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (c.func == FN_DEL_FRONT) begin
            void'(list_shadow.pop_front());
          end else begin
            void'(list_shadow.pop_back());
          end
          r.status = ST_OK;
        end
      end
      FN_DEL_POS: begin
        // On an empty list every position is out of range, so this reports
        // a bad position rather than EMPTY.
        if (p < 1 || p > n) begin
          r.status = ST_BADPOS;
        end else begin
          list_shadow.delete(p - 1);
          r.status = ST_OK;
        end
      end
      FN_DUMP: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < n; i++) begin
            r.status     = ST_OK;
            r.count      = 5'(n);
            r.item       = list_shadow[i];
            r.item_valid = 1'b1;
            r.last       = (i == n - 1);
            awaited_results.push_back(r);
          end
          return;
        end
      end
      default: begin
        r.status = ST_OK;
      end
    endcase
    r.count = 5'(list_shadow.size());
    awaited_results.push_back(r);
  endfunction

  function automatic void check_field(string name, logic signed [32:0] want,
                                      logic signed [32:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void add_cmd(logic [2:0] func, logic signed [31:0] value,
                                  logic [7:0] position);
    cmd_t c;
    c.func     = func;
    c.value    = value;
    c.position = position;
    pending_cmds.push_back(c);
  endfunction

  // Values lean on the two's complement corners, the rest is uniform.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh0000_0000;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Most positions land around the legal range of a list of up to DEPTH
  // entries so that both edges of the range are hit often; the rest cover
  // the whole 8-bit field.
  function automatic logic [7:0] pick_position();
    if ($urandom_range(0, 4) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    return 8'($urandom_range(0, DEPTH + 2));
  endfunction

  // Driver. A transaction completes at an edge where start is high and busy
  // is low; the command is then folded into the shadow list right away, and
  // its results are expected from the next cycle on. While busy is high the
  // current command is held. Otherwise the next command goes out, unless an
  // idle burst is running or starts here.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      cmd   <= '0;
      gap_left = 0;
    end else if (!start || !busy) begin
      if (start) begin
        apply_command(cmd);
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        start <= 1'b0;
      end else if (cmds_issued < cmd_total - QUIET_TAIL && $urandom_range(0, 4) == 0) begin
        // This cycle is the first idle one of the burst.
        gap_left = $urandom_range(0, 5);
        start <= 1'b0;
      end else begin
        cmd   <= pending_cmds.pop_front();
        start <= 1'b1;
        cmds_issued++;
      end
    end
  end

  // Monitor. The receiver cannot stall, so every cycle with done high is one
  // result, matched against the oldest one we are waiting for.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d count %0d item %0d",
                 $time, result.status, result.count, result.item);
        mismatch_count++;
      end else begin
        result_t want;
        want = awaited_results.pop_front();
        check_field("status", 33'(want.status), 33'(result.status));
        check_field("count", 33'(want.count), 33'(result.count));
        check_field("item", 33'(want.item), 33'(result.item));
        check_field("item_valid", 33'(want.item_valid), 33'(result.item_valid));
        check_field("last", 33'(want.last), 33'(result.last));
      end
    end
  end

  initial begin
    int kind;
    int len;
    int r;

    rst = 1'b1;

    // Directed part. It starts on an empty list, so every way of touching
    // nothing comes first: dump, both end deletes, positional deletes at the
    // bottom and top of the field, and inserts at position zero and one past
    // the end. Then the list is built up with the extreme values, probed at
    // both ends and in the middle, and taken down again so that the only
    // element is removed once by position, once from the back and once from
    // the front.
    add_cmd(FN_DUMP, 32'sd0, 8'd0);
    add_cmd(FN_DEL_FRONT, 32'sd0, 8'd0);
    add_cmd(FN_DEL_BACK, 32'sd0, 8'd0);
    add_cmd(FN_DEL_POS, 32'sd0, 8'd0);
    add_cmd(FN_DEL_POS, 32'sd0, 8'd255);
    add_cmd(FN_INS_POS, 32'sd5, 8'd0);
    add_cmd(FN_INS_POS, 32'sd6, 8'd2);
    add_cmd(FN_UNUSED, -32'sd1, 8'd255);
    add_cmd(FN_INS_FRONT, 32'sh7fff_ffff, 8'd0);
    add_cmd(FN_DEL_POS, 32'sd0, 8'd1);
    add_cmd(FN_INS_BACK, 32'sh8000_0000, 8'd0);
    add_cmd(FN_INS_POS, 32'sd0, 8'd1);
    add_cmd(FN_INS_POS, -32'sd1, 8'd3);
    add_cmd(FN_INS_POS, 32'sh5a5a_5a5a, 8'd2);
    add_cmd(FN_INS_POS, 32'sd7, 8'd6);
    add_cmd(FN_DUMP, 32'sd0, 8'd0);
    add_cmd(FN_DEL_POS, 32'sd0, 8'd5);
    add_cmd(FN_DEL_POS, 32'sd0, 8'd2);
    add_cmd(FN_DEL_FRONT, 32'sd0, 8'd0);
    add_cmd(FN_DEL_BACK, 32'sd0, 8'd0);
    add_cmd(FN_DUMP, 32'sd0, 8'd0);
    add_cmd(FN_DEL_BACK, 32'sd0, 8'd0);
    add_cmd(FN_INS_BACK, $urandom, 8'd255);
    add_cmd(FN_DEL_FRONT, 32'sd0, 8'd0);

    // Random part, built from runs. Fill runs grow the list mostly through
    // the ends, so they reach the full list and bounce off it; drain runs
    // shrink it down to empty and past it; dumps show the whole contents at
    // whatever size the list has; short noise runs use any code and any
    // position. The first run is a long fill, so a full list is seen early.
    kind = 0;
    len  = DEPTH + 4;
    while (pending_cmds.size() < 470) begin
      case (kind)
        0, 1, 2, 3: begin
          repeat (len) begin
            r = $urandom_range(0, 9);
            if (r < 4) begin
              add_cmd(FN_INS_FRONT, pick_value(), pick_position());
            end else if (r < 8) begin
              add_cmd(FN_INS_BACK, pick_value(), pick_position());
            end else begin
              add_cmd(FN_INS_POS, pick_value(), pick_position());
            end
          end
        end
        4, 5, 6: begin
          repeat (len) begin
            r = $urandom_range(0, 9);
            if (r < 4) begin
              add_cmd(FN_DEL_FRONT, pick_value(), pick_position());
            end else if (r < 7) begin
              add_cmd(FN_DEL_BACK, pick_value(), pick_position());
            end else begin
              add_cmd(FN_DEL_POS, pick_value(), pick_position());
            end
          end
        end
        7: begin
          add_cmd(FN_DUMP, pick_value(), pick_position());
        end
        default: begin
          if (kind == 9) begin
            add_cmd(FN_DUMP, pick_value(), pick_position());
          end
          repeat ($urandom_range(1, 6)) begin
            add_cmd(3'($urandom_range(0, 7)), pick_value(), 8'($urandom_range(0, 255)));
          end
        end
      endcase
      kind = $urandom_range(0, 9);
      len  = $urandom_range(4, DEPTH + 4);
    end
    cmd_total = pending_cmds.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Wait for every command to go out and every owed result to come back,
    // then leave a few cycles in which a stray result would still show up.
    while (pending_cmds.size() != 0 || start || awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    #1;
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
